@@ src/wst_pkg.sv @@
package wst_pkg;

    localparam int SLOT_W     = 4;
    localparam int WEIGHT_W   = 20;
    localparam int DUR_W      = 20;
    localparam int SRV_OUT_W  = 4;
    localparam int CFG_W      = 5;
    localparam int S_DATA_W   = 48;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TASK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic valid;
        logic any_free;
        logic have_early;
    } tok_flags_t;

endpackage

@@ src/wst_cell.sv @@
module wst_cell #(
    parameter int IDX       = 0,
    parameter int IDX_W     = 4,
    parameter int TIME_BITS = 40
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          active,
    input  logic                          load_en,
    input  logic [wst_pkg::SLOT_W-1:0]    load_slot,
    input  logic [wst_pkg::WEIGHT_W-1:0]  load_weight,
    input  logic                          wr_en,
    input  logic [IDX_W-1:0]              wr_idx,
    input  logic [TIME_BITS-1:0]          wr_time,
    input  logic [TIME_BITS-1:0]          now_in,
    input  wst_pkg::tok_flags_t           flags_in,
    input  logic [wst_pkg::WEIGHT_W-1:0]  free_w_in,
    input  logic [IDX_W-1:0]              free_idx_in,
    input  logic [TIME_BITS-1:0]          early_t_in,
    input  logic [wst_pkg::WEIGHT_W-1:0]  early_w_in,
    input  logic [IDX_W-1:0]              early_idx_in,
    output wst_pkg::tok_flags_t           flags_out,
    output logic [wst_pkg::WEIGHT_W-1:0]  free_w_out,
    output logic [IDX_W-1:0]              free_idx_out,
    output logic [TIME_BITS-1:0]          early_t_out,
    output logic [wst_pkg::WEIGHT_W-1:0]  early_w_out,
    output logic [IDX_W-1:0]              early_idx_out
);
    import wst_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [WEIGHT_W-1:0]  weight_reg;
    logic [TIME_BITS-1:0] free_at_reg;

    tok_flags_t           flags_reg, flags_next;
    logic [WEIGHT_W-1:0]  free_w_reg, free_w_next;
    logic [IDX_W-1:0]     free_idx_reg, free_idx_next;
    logic [TIME_BITS-1:0] early_t_reg, early_t_next;
    logic [WEIGHT_W-1:0]  early_w_reg, early_w_next;
    logic [IDX_W-1:0]     early_idx_reg, early_idx_next;

    logic slot_hit;
    logic free_ok;

    assign slot_hit = (32'(load_slot) == IDX);
    assign free_ok  = active && (free_at_reg <= now_in);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_at_reg <= '0;
        end else if (load_en && slot_hit) begin
            free_at_reg <= '0;
        end else if (wr_en && (wr_idx == MY_IDX)) begin
            free_at_reg <= wr_time;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en && slot_hit) begin
            weight_reg <= load_weight;
        end
    end

    always_comb begin
        flags_next     = flags_in;
        free_w_next    = free_w_in;
        free_idx_next  = free_idx_in;
        early_t_next   = early_t_in;
        early_w_next   = early_w_in;
        early_idx_next = early_idx_in;
        if (active) begin
            if (free_ok && (!flags_in.any_free || (weight_reg < free_w_in))) begin
                flags_next.any_free = 1'b1;
                free_w_next         = weight_reg;
                free_idx_next       = MY_IDX;
            end
            if (!flags_in.have_early || (free_at_reg < early_t_in) ||
                ((free_at_reg == early_t_in) && (weight_reg < early_w_in))) begin
                flags_next.have_early = 1'b1;
                early_t_next          = free_at_reg;
                early_w_next          = weight_reg;
                early_idx_next        = MY_IDX;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge aclk) begin
        free_w_reg    <= free_w_next;
        free_idx_reg  <= free_idx_next;
        early_t_reg   <= early_t_next;
        early_w_reg   <= early_w_next;
        early_idx_reg <= early_idx_next;
    end

    assign flags_out     = flags_reg;
    assign free_w_out    = free_w_reg;
    assign free_idx_out  = free_idx_reg;
    assign early_t_out   = early_t_reg;
    assign early_w_out   = early_w_reg;
    assign early_idx_out = early_idx_reg;

endmodule

@@ src/weighted_server_task_assigner_core.sv @@
// Channel | Dir | Handshake           | Contents
// s_      | in  | s_tvalid / s_tready | tuser: cmd; tdata: slot, weight, duration
// m_      | out | m_tvalid / m_tready | tdata: assigned_server, start_time
// cfg_    | in  | cfg_valid/cfg_ready | cfg_data: active_servers
//
// A load item is taken whenever the block is idle. A task item holds s_tready low
// after its accept until its result has gone to the output register, so no new item
// is taken while a task is in flight: a token walks the server chain one cell per cycle,
// then the choice is committed and the result moves to the output register.
// Reset (aresetn low, synchronous) frees every server and clears time and task count.
// A result left waiting on m_ holds the next task before the output register, with
// s_tready low, until m_tready takes the waiting item.
module weighted_server_task_assigner_core #(
    parameter int NUM_SERVERS = 16,
    parameter int TIME_BITS   = 40,
    localparam int M_DATA_W   = ((wst_pkg::SRV_OUT_W + TIME_BITS + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [3:0] server_slot, [23:4] weight, [43:24] duration, [47:44] zero
    input  logic [wst_pkg::S_DATA_W-1:0]  s_tdata,
    // [0] cmd
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [3:0] assigned_server, [TIME_BITS+3:4] start_time, rest zero
    output logic [M_DATA_W-1:0]           m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wst_pkg::CFG_W-1:0]     cfg_data
);
    import wst_pkg::*;

    localparam int IDX_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]     active_servers_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [TIME_BITS-1:0] task_count_reg;
    logic [DUR_W-1:0]     dur_reg;
    logic                 launch_reg, launch_next;
    logic [IDX_W-1:0]     pend_idx_reg;
    logic [TIME_BITS-1:0] pend_time_reg;
    logic                 m_tvalid_reg;
    logic [IDX_W-1:0]     m_server_reg;
    logic [TIME_BITS-1:0] m_time_reg;

    logic [SLOT_W-1:0]    in_slot;
    logic [WEIGHT_W-1:0]  in_weight;
    logic [DUR_W-1:0]     in_dur;
    logic                 s_acc;
    logic                 load_en;
    logic                 commit;
    logic                 out_load;

    logic [TIME_BITS-1:0] now_max;
    logic [TIME_BITS-1:0] now_new;
    logic [IDX_W-1:0]     best_idx;
    logic [TIME_BITS:0]   end_sum;
    logic [TIME_BITS-1:0] end_time;
    logic [TIME_BITS-1:0] task_inc;

    logic [NUM_SERVERS-1:0] act;

    tok_flags_t           c_flags   [NUM_SERVERS+1];
    logic [WEIGHT_W-1:0]  c_free_w  [NUM_SERVERS+1];
    logic [IDX_W-1:0]     c_free_i  [NUM_SERVERS+1];
    logic [TIME_BITS-1:0] c_early_t [NUM_SERVERS+1];
    logic [WEIGHT_W-1:0]  c_early_w [NUM_SERVERS+1];
    logic [IDX_W-1:0]     c_early_i [NUM_SERVERS+1];

    assign in_slot   = s_tdata[SLOT_W-1:0];
    assign in_weight = s_tdata[SLOT_W +: WEIGHT_W];
    assign in_dur    = s_tdata[SLOT_W + WEIGHT_W +: DUR_W];

    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_servers_reg <= ACTIVE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            active_servers_reg <= cfg_data;
        end
    end

    // Cell 0 always counts as active; any other cell i is active when active_servers exceeds i.
    for (genvar i = 0; i < NUM_SERVERS; i++) begin : g_act
        assign act[i] = (i == 0) || (32'(active_servers_reg) > 32'(i));
    end

    assign c_flags[0]   = '{valid: launch_reg, any_free: 1'b0, have_early: 1'b0};
    assign c_free_w[0]  = '0;
    assign c_free_i[0]  = '0;
    assign c_early_t[0] = '0;
    assign c_early_w[0] = '0;
    assign c_early_i[0] = '0;

    for (genvar i = 0; i < NUM_SERVERS; i++) begin : g_cell
        wst_cell #(
            .IDX       (i),
            .IDX_W     (IDX_W),
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .active        (act[i]),
            .load_en       (load_en),
            .load_slot     (in_slot),
            .load_weight   (in_weight),
            .wr_en         (commit),
            .wr_idx        (best_idx),
            .wr_time       (end_time),
            .now_in        (now_reg),
            .flags_in      (c_flags[i]),
            .free_w_in     (c_free_w[i]),
            .free_idx_in   (c_free_i[i]),
            .early_t_in    (c_early_t[i]),
            .early_w_in    (c_early_w[i]),
            .early_idx_in  (c_early_i[i]),
            .flags_out     (c_flags[i+1]),
            .free_w_out    (c_free_w[i+1]),
            .free_idx_out  (c_free_i[i+1]),
            .early_t_out   (c_early_t[i+1]),
            .early_w_out   (c_early_w[i+1]),
            .early_idx_out (c_early_i[i+1])
        );
    end

    assign now_max  = (task_count_reg > now_reg) ? task_count_reg : now_reg;
    assign now_new  = c_flags[NUM_SERVERS].any_free ? now_reg : c_early_t[NUM_SERVERS];
    assign best_idx = c_flags[NUM_SERVERS].any_free ? c_free_i[NUM_SERVERS]
                                                    : c_early_i[NUM_SERVERS];
    assign end_sum  = {1'b0, now_new} + (TIME_BITS+1)'(dur_reg);
    assign end_time = end_sum[TIME_BITS] ? '1 : end_sum[TIME_BITS-1:0];
    assign task_inc = (&task_count_reg) ? task_count_reg : task_count_reg + TIME_BITS'(1);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && (s_tuser == CMD_TASK)) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (c_flags[NUM_SERVERS].valid) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        load_en     = 1'b0;
        launch_next = 1'b0;
        commit      = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                load_en     = s_tvalid && (s_tuser == CMD_LOAD);
                launch_next = s_tvalid && (s_tuser == CMD_TASK);
            end
            ST_SCAN: begin
                commit = c_flags[NUM_SERVERS].valid;
            end
            ST_HOLD: begin
                out_load = !m_tvalid_reg || m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            launch_reg     <= 1'b0;
            now_reg        <= '0;
            task_count_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
            if (launch_next) begin
                now_reg <= now_max;
            end else if (commit) begin
                now_reg        <= now_new;
                task_count_reg <= task_inc;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (launch_next) begin
            dur_reg <= in_dur;
        end
        if (commit) begin
            pend_idx_reg  <= best_idx;
            pend_time_reg <= now_new;
        end
        if (out_load) begin
            m_server_reg <= pend_idx_reg;
            m_time_reg   <= pend_time_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'({m_time_reg, SRV_OUT_W'(m_server_reg)});

endmodule
